### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/dfhp_pkg.sv
// ---------------------------------------------------------------------------
// dfhp_pkg
// Types, tables and helpers for the fixed Huffman DEFLATE token packer.
// ---------------------------------------------------------------------------
package dfhp_pkg;

  typedef enum logic [1:0] {
    OP_HEADER  = 2'd0,
    OP_LITERAL = 2'd1,
    OP_MATCH   = 2'd2,
    OP_EOB     = 2'd3
  } op_t;

  localparam int unsigned CODE_W  = 31;  // longest token: 8 + 5 + 5 + 13
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned ACC_W   = 38;  // 7 pending bits + longest token

  // encoded token, passed from encoder to packer
  typedef struct packed {
    logic [CODE_W-1:0]  bits;
    logic [COUNT_W-1:0] count;
    logic               eob;
  } enc_t;

  localparam logic [8:0] LEN_BASE [0:28] = '{
    9'd3,   9'd4,   9'd5,   9'd6,   9'd7,   9'd8,   9'd9,   9'd10,
    9'd11,  9'd13,  9'd15,  9'd17,  9'd19,  9'd23,  9'd27,  9'd31,
    9'd35,  9'd43,  9'd51,  9'd59,  9'd67,  9'd83,  9'd99,  9'd115,
    9'd131, 9'd163, 9'd195, 9'd227, 9'd258
  };

  localparam logic [2:0] LEN_XBITS [0:28] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd0
  };

  localparam logic [15:0] DST_BASE [0:29] = '{
    16'd1,     16'd2,     16'd3,     16'd4,     16'd5,     16'd7,
    16'd9,     16'd13,    16'd17,    16'd25,    16'd33,    16'd49,
    16'd65,    16'd97,    16'd129,   16'd193,   16'd257,   16'd385,
    16'd513,   16'd769,   16'd1025,  16'd1537,  16'd2049,  16'd3073,
    16'd4097,  16'd6145,  16'd8193,  16'd12289, 16'd16385, 16'd24577
  };

  localparam logic [3:0] DST_XBITS [0:29] = '{
    4'd0,  4'd0,  4'd0,  4'd0,  4'd1,  4'd1,  4'd2,  4'd2,
    4'd3,  4'd3,  4'd4,  4'd4,  4'd5,  4'd5,  4'd6,  4'd6,
    4'd7,  4'd7,  4'd8,  4'd8,  4'd9,  4'd9,  4'd10, 4'd10,
    4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
  };

  localparam int unsigned LAST_SHORT_LEN_IDX = 22;  // symbols up to 279 use 7 bits

  // largest length code whose base does not exceed len
  function automatic logic [4:0] len_index(input logic [8:0] len);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 29; i++) begin
      if (len >= LEN_BASE[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  // largest distance code whose base does not exceed dst
  function automatic logic [4:0] dst_index(input logic [15:0] dst);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 30; i++) begin
      if (dst >= DST_BASE[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  // bit reversal of a 9-bit word; a k-bit code is passed left aligned
  function automatic logic [8:0] rev9(input logic [8:0] x);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) begin
      r[i] = x[8-i];
    end
    return r;
  endfunction

endpackage

### rtl/core/dfhp_encoder.sv
// ---------------------------------------------------------------------------
// dfhp_encoder
// Input register and fixed Huffman token encoder with a registered result.
// ---------------------------------------------------------------------------
module dfhp_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_literal,
  input  logic [8:0]        in_length,
  input  logic [15:0]       in_distance,
  output logic              enc_valid,
  input  logic              enc_ready,
  output dfhp_pkg::enc_t    enc
);
  import dfhp_pkg::*;

  logic        tok_valid;
  logic [1:0]  tok_op;
  logic [7:0]  tok_literal;
  logic [8:0]  tok_length;
  logic [15:0] tok_distance;
  logic        tok_ready;

  enc_t        enc_next;
  logic [8:0]  len_c;
  logic [15:0] dst_c;
  logic [4:0]  li;
  logic [4:0]  di;
  logic [8:0]  sym_rev;
  logic [3:0]  ks;
  logic [2:0]  lx;
  logic [4:0]  le;
  logic [4:0]  dc;
  logic [3:0]  dx;
  logic [12:0] de;
  logic [8:0]  lit_rev;

  assign tok_ready = !enc_valid || enc_ready;
  assign in_ready  = !tok_valid || tok_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (in_ready) begin
      tok_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      tok_op       <= in_op;
      tok_literal  <= in_literal;
      tok_length   <= in_length;
      tok_distance <= in_distance;
    end
  end

  always_comb begin
    len_c = tok_length;
    if (len_c < 9'd3) len_c = 9'd3;
    if (len_c > 9'd258) len_c = 9'd258;
    dst_c = tok_distance;
    if (dst_c == 16'd0) dst_c = 16'd1;
    if (dst_c > 16'd32768) dst_c = 16'd32768;

    li = len_index(len_c);
    di = dst_index(dst_c);

    if (li <= 5'(LAST_SHORT_LEN_IDX)) begin
      sym_rev = rev9({7'(li + 5'd1), 2'b00});
      ks      = 4'd7;
    end else begin
      sym_rev = rev9({8'hC0 + 8'(li - 5'd23), 1'b0});
      ks      = 4'd8;
    end
    lx = LEN_XBITS[li];
    le = 5'(len_c - LEN_BASE[li]);
    dc = 5'(rev9({di, 4'b0000}));
    dx = DST_XBITS[di];
    de = 13'(dst_c - DST_BASE[di]);

    if (tok_literal < 8'd144) begin
      lit_rev = rev9({tok_literal + 8'h30, 1'b0});
    end else begin
      lit_rev = rev9({1'b1, tok_literal});
    end

    enc_next = '0;
    unique case (op_t'(tok_op))
      OP_HEADER: begin
        enc_next.bits  = CODE_W'(3);
        enc_next.count = 5'd3;
      end
      OP_LITERAL: begin
        enc_next.bits  = CODE_W'(lit_rev);
        enc_next.count = (tok_literal < 8'd144) ? 5'd8 : 5'd9;
      end
      OP_MATCH: begin
        enc_next.bits  = CODE_W'(sym_rev)
                       | (CODE_W'(le) << ks)
                       | (CODE_W'(dc) << (5'(ks) + 5'(lx)))
                       | (CODE_W'(de) << (5'(ks) + 5'(lx) + 5'd5));
        enc_next.count = 5'(ks) + 5'(lx) + 5'd5 + 5'(dx);
      end
      OP_EOB: begin
        enc_next.bits  = '0;
        enc_next.count = 5'd7;
        enc_next.eob   = 1'b1;
      end
      default: enc_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_valid <= 1'b0;
    end else if (tok_ready) begin
      enc_valid <= tok_valid;
    end
    if (tok_valid && tok_ready) begin
      enc <= enc_next;
    end
  end

endmodule

### rtl/core/dfhp_packer.sv
// ---------------------------------------------------------------------------
// dfhp_packer
// Merges encoded tokens with pending bits and streams out completed bytes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dfhp_packer (
  input  logic            clk,
  input  logic            rst,
  input  logic            enc_valid,
  output logic            enc_ready,
  input  dfhp_pkg::enc_t  enc,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_end
);
  import dfhp_pkg::*;

  logic [6:0]       pbits;
  logic [2:0]       pcount;
  logic [31:0]      obuf;
  logic [2:0]       rem;
  logic             oend;

  logic [5:0]       total;
  logic [5:0]       total_r;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_sh;
  logic [2:0]       nbytes;
  logic             buf_free;
  logic             load;
  logic             pop;

  always_comb begin
    total   = 6'(pcount) + 6'(enc.count);
    total_r = enc.eob ? ((total + 6'd7) & 6'b111000) : total;
    nbytes  = total_r[5:3];
    acc     = ACC_W'(pbits) | (ACC_W'(enc.bits) << pcount);
    acc_sh  = acc >> {nbytes, 3'b000};
  end

  assign pop       = out_valid && out_ready;
  assign buf_free  = (rem == 3'd0) || (rem == 3'd1 && out_ready);
  assign enc_ready = (nbytes == 3'd0) || buf_free;
  assign load      = enc_valid && enc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pbits  <= '0;
      pcount <= '0;
      rem    <= '0;
      oend   <= 1'b0;
    end else begin
      if (load) begin
        pbits  <= enc.eob ? 7'd0 : acc_sh[6:0];
        pcount <= enc.eob ? 3'd0 : total[2:0];
      end
      if (load && nbytes != 3'd0) begin
        obuf <= acc[31:0];
        rem  <= nbytes;
        oend <= enc.eob;
      end else if (pop) begin
        obuf <= {8'h00, obuf[31:8]};
        rem  <= rem - 3'd1;
      end
    end
  end

  assign out_valid = (rem != 3'd0);
  assign out_byte  = obuf[7:0];
  assign out_last  = (rem == 3'd1);
  assign out_end   = oend && (rem == 3'd1);

  `ASSERT_ALWAYS(a_rem_range, rem <= 3'd4, "output buffer holds more than four bytes")
  `ASSERT_IMPL(a_end_is_last, out_valid && out_end, out_last, "stream end off the last byte")
  `ASSERT_IMPL(a_eob_emits, load && enc.eob, nbytes != 3'd0, "end of block produced no byte")
  `ASSERT_NEXT(a_eob_clears, load && enc.eob, pcount == 3'd0 && pbits == 7'd0,
               "pending bits left after end of block")
  `ASSERT_IMPL(a_no_overwrite, load && nbytes != 3'd0, buf_free,
               "bytes loaded over an unfinished run")

endmodule

### rtl/core/deflate_fixed_huffman_token_packer.sv
// ---------------------------------------------------------------------------
// deflate_fixed_huffman_token_packer
// DEFLATE fixed Huffman token encoder with LSB-first byte packing.
// ---------------------------------------------------------------------------
// A token passes the input register, the encoder result register and the run buffer before its first byte is presented.
// Throughput: one token per cycle while each yields at most one byte and m_tready
// is held high; otherwise one token per output byte, since the one-byte output
// port drains a four-byte run buffer to its last byte before the next run loads.
// Reset (synchronous, rst high) empties the pipeline and clears the pending bits.
module deflate_fixed_huffman_token_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // literal_byte[7:0], match_length[16:8],
                                 // match_distance[32:17], zero[39:33]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast,   // last_of_run
  output logic        m_tuser    // stream_end
);
  import dfhp_pkg::*;

  logic enc_valid;
  logic enc_ready;
  enc_t enc;

  dfhp_encoder u_encoder (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tuser),
    .in_literal  (s_tdata[7:0]),
    .in_length   (s_tdata[16:8]),
    .in_distance (s_tdata[32:17]),
    .enc_valid   (enc_valid),
    .enc_ready   (enc_ready),
    .enc         (enc)
  );

  dfhp_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .enc_valid (enc_valid),
    .enc_ready (enc_ready),
    .enc       (enc),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast),
    .out_end   (m_tuser)
  );

endmodule
